// File: design/assert_macros.svh
// Assertion macros for the serial flash sequencer RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SFCS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define SFCS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define SFCS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/sfcs_pkg.sv
// Package for the serial flash command sequencer: request and result types,
// action and error codes, flash command opcodes. No dependencies.
`default_nettype none

package sfcs_pkg;

    localparam int ADDR_BITS = 24;
    localparam logic [23:0] ADDR_MASK = 24'((32'd1 << ADDR_BITS) - 32'd1);

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_PROG  = 3'd3;
    localparam logic [2:0] ACT_ERASE = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_PROTECT = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;
    localparam logic [1:0] ERR_BUSY    = 2'd3;

    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_PROG  = 8'h02;
    localparam logic [7:0] CMD_ERASE = 8'h20;
    localparam logic [7:0] CMD_RDSR  = 8'h05;

    localparam logic [23:0] PROTECT_RESET = 24'h200000;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic [7:0]  buffer_index;
        logic        miso;
    } sfcs_item_t;

    typedef struct packed {
        logic       cs_n;
        logic       mosi;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       busy_res;
        logic       done_res;
        logic [1:0] error_code;
    } sfcs_result_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } buf_wr_t;

endpackage

`default_nettype wire

// File: design/sfcs_if.sv
// Channel interfaces of the serial flash command sequencer: request,
// result and configuration write. Valid/ready handshake, no dependencies.
`default_nettype none

interface sfcs_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic [7:0]  buffer_index;
    logic        miso;

    modport source (output valid, action, address, length, data_byte, buffer_index, miso,
                     input ready);
    modport sink (input valid, action, address, length, data_byte, buffer_index, miso,
                   output ready);
endinterface

interface sfcs_rsp_if;
    logic       valid;
    logic       ready;
    logic       cs_n;
    logic       mosi;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       done_res;
    logic [1:0] error_code;

    modport source (output valid, cs_n, mosi, read_valid, read_byte, busy_res, done_res,
                     error_code, input ready);
    modport sink (input valid, cs_n, mosi, read_valid, read_byte, busy_res, done_res,
                   error_code, output ready);
endinterface

interface sfcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/sfcs_page_buf.sv
// Page buffer memory: one write port, one registered read port with
// write-first bypass. Depends on sfcs_pkg for the write request type.
`default_nettype none

module sfcs_page_buf
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES = 256
) (
    input  wire logic       clk,
    input  wire buf_wr_t    wr,
    input  wire logic [7:0] rd_addr,
    output logic [7:0]      rd_data
);

    localparam int PIDX_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    logic [7:0] mem [PAGE_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[PIDX_W-1:0]] <= wr.data;
        end
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr[PIDX_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/sfcs_core.sv
// Command sequencer state machine: frames, bit shifting, status polling and
// request checks. Depends on sfcs_pkg; page bytes come from sfcs_page_buf.
`default_nettype none

module sfcs_core
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         proc,
    input  wire sfcs_item_t   item,
    input  wire logic [23:0]  protect_limit,
    input  wire logic [7:0]   rd_data,
    output sfcs_result_t      res,
    output buf_wr_t           wr,
    output logic [7:0]        rd_addr
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WREN,
        PH_GAP,
        PH_CMD,
        PH_DOUT,
        PH_DIN,
        PH_SCMD,
        PH_SIN
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_PROG,
        OP_ERASE
    } op_t;

    phase_t      phase_reg,     phase_next;
    op_t         op_reg,        op_next;
    logic [5:0]  bit_cnt_reg,   bit_cnt_next;
    logic [31:0] shift_out_reg, shift_out_next;
    logic [7:0]  shift_in_reg,  shift_in_next;
    logic [15:0] byte_cnt_reg,  byte_cnt_next;
    logic [15:0] total_reg,     total_next;
    logic [23:0] target_reg,    target_next;

    logic [5:0]  bit_inc;
    logic [15:0] byte_inc;
    logic [7:0]  sin_shift;
    logic [23:0] addr_m;

    assign bit_inc   = bit_cnt_reg + 6'd1;
    assign byte_inc  = byte_cnt_reg + 16'd1;
    assign sin_shift = {shift_in_reg[6:0], item.miso};
    assign addr_m    = item.address & ADDR_MASK;

    // The next page byte is fetched ahead of the end of the current data byte.
    always_comb
    begin
        rd_addr = 8'd0;
        if ((phase_reg == PH_DOUT) && ({1'b0, byte_inc} < 17'(PAGE_BYTES)))
        begin
            rd_addr = byte_inc[7:0];
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        op_next        = op_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        byte_cnt_next  = byte_cnt_reg;
        total_next     = total_reg;
        target_next    = target_reg;

        res.cs_n       = 1'b1;
        res.mosi       = 1'b0;
        res.read_valid = 1'b0;
        res.read_byte  = 8'd0;
        res.done_res   = 1'b0;
        res.error_code = ERR_NONE;

        wr.en   = 1'b0;
        wr.addr = item.buffer_index;
        wr.data = item.data_byte;

        if (proc)
        begin
            unique case (item.action) inside
                ACT_TICK:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            phase_next = PH_IDLE;
                        end
                        PH_GAP:
                        begin
                            if (bit_cnt_reg == 6'd0)
                            begin
                                phase_next     = PH_CMD;
                                shift_out_next = {(op_reg == OP_ERASE) ? CMD_ERASE : CMD_PROG,
                                                  target_reg};
                            end
                            else
                            begin
                                phase_next     = PH_SCMD;
                                shift_out_next = {CMD_RDSR, 24'd0};
                            end
                            bit_cnt_next = 6'd0;
                        end
                        PH_DIN, PH_SIN:
                        begin
                            res.cs_n      = 1'b0;
                            shift_in_next = sin_shift;
                            bit_cnt_next  = bit_inc;
                            if (bit_inc >= 6'd8)
                            begin
                                bit_cnt_next   = 6'd0;
                                res.read_valid = 1'b1;
                                res.read_byte  = sin_shift;
                                if (phase_reg == PH_DIN)
                                begin
                                    byte_cnt_next = byte_inc;
                                    if (byte_inc >= total_reg)
                                    begin
                                        phase_next   = PH_IDLE;
                                        op_next      = OP_NONE;
                                        res.done_res = 1'b1;
                                    end
                                end
                                else if (!sin_shift[0])
                                begin
                                    phase_next   = PH_IDLE;
                                    op_next      = OP_NONE;
                                    res.done_res = 1'b1;
                                end
                                else
                                begin
                                    phase_next     = PH_SCMD;
                                    shift_out_next = {CMD_RDSR, 24'd0};
                                end
                            end
                        end
                        default:
                        begin
                            res.cs_n       = 1'b0;
                            res.mosi       = shift_out_reg[31];
                            shift_out_next = {shift_out_reg[30:0], 1'b0};
                            bit_cnt_next   = bit_inc;
                            unique case (phase_reg)
                                PH_WREN:
                                begin
                                    if (bit_inc >= 6'd8)
                                    begin
                                        phase_next   = PH_GAP;
                                        bit_cnt_next = 6'd0;
                                    end
                                end
                                PH_CMD:
                                begin
                                    if (bit_inc >= 6'd32)
                                    begin
                                        bit_cnt_next = 6'd0;
                                        if (op_reg == OP_READ)
                                        begin
                                            if (total_reg == 16'd0)
                                            begin
                                                phase_next   = PH_IDLE;
                                                op_next      = OP_NONE;
                                                res.done_res = 1'b1;
                                            end
                                            else
                                            begin
                                                phase_next    = PH_DIN;
                                                byte_cnt_next = 16'd0;
                                                shift_in_next = 8'd0;
                                            end
                                        end
                                        else if ((op_reg == OP_PROG) && (total_reg != 16'd0))
                                        begin
                                            phase_next     = PH_DOUT;
                                            byte_cnt_next  = 16'd0;
                                            shift_out_next = {rd_data, 24'd0};
                                        end
                                        else
                                        begin
                                            phase_next   = PH_GAP;
                                            bit_cnt_next = 6'd1;
                                        end
                                    end
                                end
                                PH_DOUT:
                                begin
                                    if (bit_inc >= 6'd8)
                                    begin
                                        bit_cnt_next  = 6'd0;
                                        byte_cnt_next = byte_inc;
                                        if (byte_inc >= total_reg)
                                        begin
                                            phase_next   = PH_GAP;
                                            bit_cnt_next = 6'd1;
                                        end
                                        else
                                        begin
                                            shift_out_next = {rd_data, 24'd0};
                                        end
                                    end
                                end
                                PH_SCMD:
                                begin
                                    if (bit_inc >= 6'd8)
                                    begin
                                        phase_next    = PH_SIN;
                                        bit_cnt_next  = 6'd0;
                                        shift_in_next = 8'd0;
                                    end
                                end
                                default:
                                begin
                                    phase_next = phase_reg;
                                end
                            endcase
                        end
                    endcase
                end
                ACT_LOAD:
                begin
                    wr.en = ({1'b0, item.buffer_index} < 9'(PAGE_BYTES));
                end
                ACT_READ, ACT_PROG, ACT_ERASE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        res.error_code = ERR_BUSY;
                    end
                    else if ((item.action != ACT_READ) && (addr_m < protect_limit))
                    begin
                        res.error_code = ERR_PROTECT;
                    end
                    else if ((item.action == ACT_PROG) &&
                             ({1'b0, item.length} > 17'(PAGE_BYTES)))
                    begin
                        res.error_code = ERR_LENGTH;
                    end
                    else
                    begin
                        target_next   = addr_m;
                        bit_cnt_next  = 6'd0;
                        byte_cnt_next = 16'd0;
                        if (item.action == ACT_READ)
                        begin
                            op_next        = OP_READ;
                            total_next     = item.length;
                            phase_next     = PH_CMD;
                            shift_out_next = {CMD_READ, addr_m};
                        end
                        else
                        begin
                            op_next        = (item.action == ACT_PROG) ? OP_PROG : OP_ERASE;
                            total_next     = (item.action == ACT_PROG) ? item.length : 16'd0;
                            phase_next     = PH_WREN;
                            shift_out_next = {CMD_WREN, 24'd0};
                        end
                    end
                end
                default:
                begin
                    wr.en = 1'b0;
                end
            endcase

            if (item.action != ACT_TICK)
            begin
                res.cs_n = (phase_next == PH_IDLE) || (phase_next == PH_GAP);
            end
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            op_reg        <= OP_NONE;
            bit_cnt_reg   <= 6'd0;
            shift_out_reg <= 32'd0;
            shift_in_reg  <= 8'd0;
            byte_cnt_reg  <= 16'd0;
            total_reg     <= 16'd0;
            target_reg    <= 24'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_out_reg <= shift_out_next;
            shift_in_reg  <= shift_in_next;
            byte_cnt_reg  <= byte_cnt_next;
            total_reg     <= total_next;
            target_reg    <= target_next;
        end
    end

endmodule

`default_nettype wire

// File: design/spi_flash_command_sequencer.sv
// Top level of the serial flash command sequencer: input register, result
// register, protect limit register. Uses sfcs_pkg, sfcs_if, sfcs_core, sfcs_page_buf.
`default_nettype none

// Each request is one action: a tick is one serial bit period, and every request
// returns exactly one result. A request can be taken in every clock cycle while the
// result register is free or being drained; it waits in the input register, passes
// the sequencer logic once and lands in the result register. The rate is set by the
// update of the sequencer state once per request; page bytes for a program are
// fetched from the buffer memory ahead of the byte boundary, through its registered
// read port. The buffer needs no clearing pass after reset. Protect limit writes
// are expected only while no operation runs and no request is in flight.
module spi_flash_command_sequencer
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfcs_cmd_if.sink   cmd,
    sfcs_rsp_if.source rsp,
    sfcs_cfg_if.sink   cfg
);

    `include "assert_macros.svh"

    logic         in_valid_reg, in_valid_next;
    sfcs_item_t   in_item_reg;
    logic         out_valid_reg, out_valid_next;
    sfcs_result_t out_res_reg;
    logic [23:0]  protect_reg;

    logic         adv;
    logic         proc;
    sfcs_result_t core_res;
    buf_wr_t      buf_wr;
    logic [7:0]   buf_rd_addr;
    logic [7:0]   buf_rd_data;

    assign adv       = !out_valid_reg || rsp.ready;
    assign proc      = in_valid_reg && adv;
    assign cmd.ready = !in_valid_reg || adv;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd.valid && cmd.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            protect_reg   <= PROTECT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                protect_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_item_reg.action       <= cmd.action;
            in_item_reg.address      <= cmd.address;
            in_item_reg.length       <= cmd.length;
            in_item_reg.data_byte    <= cmd.data_byte;
            in_item_reg.buffer_index <= cmd.buffer_index;
            in_item_reg.miso         <= cmd.miso;
        end
        if (proc)
        begin
            out_res_reg <= core_res;
        end
    end

    sfcs_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .proc          (proc),
        .item          (in_item_reg),
        .protect_limit (protect_reg),
        .rd_data       (buf_rd_data),
        .res           (core_res),
        .wr            (buf_wr),
        .rd_addr       (buf_rd_addr)
    );

    sfcs_page_buf #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_buf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.cs_n       = out_res_reg.cs_n;
    assign rsp.mosi       = out_res_reg.mosi;
    assign rsp.read_valid = out_res_reg.read_valid;
    assign rsp.read_byte  = out_res_reg.read_byte;
    assign rsp.busy_res   = out_res_reg.busy_res;
    assign rsp.done_res   = out_res_reg.done_res;
    assign rsp.error_code = out_res_reg.error_code;

    `SFCS_ASSERT_IMP(a_read_in_frame, rsp.valid && rsp.read_valid, !rsp.cs_n, "read byte outside a frame")
    `SFCS_ASSERT_IMP(a_done_not_busy, rsp.valid && rsp.done_res, !rsp.busy_res, "done while still busy")
    `SFCS_ASSERT_IMP(a_error_quiet, rsp.valid && (rsp.error_code != ERR_NONE), !rsp.done_res && !rsp.mosi, "refused request drove the bus")
    `SFCS_ASSERT_NEXT(a_request_kept, in_valid_reg && !proc, in_valid_reg, "stalled request lost")

endmodule

`default_nettype wire
